// ===== src/dqc_pkg.sv =====
package dqc_pkg;

  localparam int RPM_W = 32;
  localparam int MS_W  = 16;
  localparam int CPR_W = 16;
  localparam int DEN_W = CPR_W + MS_W;

  // milliseconds in one minute
  localparam logic [15:0] MS_PER_MIN = 16'(1000 * 60);

  typedef enum logic [0:0] {
    REG_COUNTS_PER_REV = 1'b0,
    REG_INTERVAL_MS    = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic busy;
    logic ready;
  } spd_stat_t;

endpackage

// ===== src/dual_quadrature_counter_rpm.sv =====
// Dual quadrature encoder counter with windowed speed output. Each accepted
// sample carries both wheels' A/B pin levels and a millisecond tick; every
// sample is counted in x4 decoding with saturating tallies and the window
// timer advances on ticks. While counting, one sample is taken every cycle.
// When the timer reaches interval_ms (or 1 if interval_ms is 0), that sample
// closes the window: the tallies and timer clear and one speed lane per wheel
// computes tally * 60000 * 2^FRAC_BITS / (counts_per_rev * elapsed) with a
// radix-2 restoring divider, one quotient bit per cycle. The input then stalls
// through the multiply, COUNT_BITS + FRAC_BITS + 16 divide steps, saturation
// and transfer to the output register, and for longer while an earlier result
// still waits in the output register; sampling then resumes even if the new
// result has not yet been taken. Speeds are signed fixed point with FRAC_BITS
// fraction bits, truncated toward zero and saturated to 32 bits.
module dual_quadrature_counter_rpm #(
  parameter int COUNT_BITS = 24,
  parameter int FRAC_BITS  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // left_a_level, left_b_level, right_a_level, right_b_level, ms_tick
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // left_rpm, right_rpm, window_ms
  input  logic        cfg_wen,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import dqc_pkg::*;

  logic [CPR_W-1:0]             counts_per_rev;
  logic [MS_W-1:0]              interval_ms;
  logic [MS_W-1:0]              elapsed;
  logic [MS_W-1:0]              elapsed_next;
  logic [MS_W-1:0]              need;
  logic [MS_W-1:0]              win_ms;
  logic                         step;
  logic                         fire;
  logic                         take;
  logic signed [COUNT_BITS-1:0] l_count;
  logic signed [COUNT_BITS-1:0] r_count;
  logic [RPM_W-1:0]             l_rpm;
  logic [RPM_W-1:0]             r_rpm;
  spd_stat_t                    l_stat;
  spd_stat_t                    r_stat;

  assign s_tready = ~l_stat.busy & ~r_stat.busy;
  assign step     = s_tvalid & s_tready;

  always_comb begin
    elapsed_next = (s_tdata[4] && elapsed != '1) ? elapsed + MS_W'(1) : elapsed;
    need         = (interval_ms == '0) ? MS_W'(1) : interval_ms;
    fire         = step & (elapsed_next >= need);
    take         = l_stat.ready & r_stat.ready & (~m_tvalid | m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counts_per_rev <= CPR_W'(1);
      interval_ms    <= MS_W'(100);
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_COUNTS_PER_REV: counts_per_rev <= cfg_wdata;
        REG_INTERVAL_MS:    interval_ms    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed <= '0;
    end else if (step) begin
      elapsed <= fire ? '0 : elapsed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      win_ms <= elapsed_next;
    end
  end

  // lanes: one tally and one speed unit per wheel
  dqc_tally #(.COUNT_BITS(COUNT_BITS)) u_l_tally (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .clear      (fire),
    .a_lvl      (s_tdata[0]),
    .b_lvl      (s_tdata[1]),
    .count_next (l_count)
  );

  dqc_tally #(.COUNT_BITS(COUNT_BITS)) u_r_tally (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .clear      (fire),
    .a_lvl      (s_tdata[2]),
    .b_lvl      (s_tdata[3]),
    .count_next (r_count)
  );

  dqc_speed #(.COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)) u_l_speed (
    .clk   (clk),
    .rst   (rst),
    .start (fire),
    .ack   (take),
    .count (l_count),
    .cpr   (counts_per_rev),
    .ms    (elapsed_next),
    .rpm   (l_rpm),
    .stat  (l_stat)
  );

  dqc_speed #(.COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)) u_r_speed (
    .clk   (clk),
    .rst   (rst),
    .start (fire),
    .ack   (take),
    .count (r_count),
    .cpr   (counts_per_rev),
    .ms    (elapsed_next),
    .rpm   (r_rpm),
    .stat  (r_stat)
  );

  // merge both lanes into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= {win_ms, r_rpm, l_rpm};
    end
  end

endmodule

// ===== src/dqc_tally.sv =====
module dqc_tally #(
  parameter int COUNT_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic                         clear,
  input  logic                         a_lvl,
  input  logic                         b_lvl,
  output logic signed [COUNT_BITS-1:0] count_next
);
  import dqc_pkg::*;

  localparam logic signed [COUNT_BITS-1:0] HI = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic signed [COUNT_BITS-1:0] LO = {1'b1, {(COUNT_BITS-1){1'b0}}};

  logic                         a_prev;
  logic                         b_prev;
  logic signed [COUNT_BITS-1:0] count;
  logic                         a_ch;
  logic                         b_ch;
  logic                         up;
  logic                         dn;

  always_comb begin
    a_ch = a_lvl ^ a_prev;
    b_ch = b_lvl ^ b_prev;
    up   = (a_ch & ~b_ch & (a_lvl == b_lvl)) | (b_ch & ~a_ch & (a_lvl != b_lvl));
    dn   = (a_ch ^ b_ch) & ~up;
    if (up && count != HI) begin
      count_next = count + COUNT_BITS'(1);
    end else if (dn && count != LO) begin
      count_next = count - COUNT_BITS'(1);
    end else begin
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_prev <= 1'b0;
      b_prev <= 1'b0;
      count  <= '0;
    end else if (step) begin
      a_prev <= a_lvl;
      b_prev <= b_lvl;
      count  <= clear ? '0 : count_next;
    end
  end

endmodule

// ===== src/dqc_speed.sv =====
module dqc_speed #(
  parameter int COUNT_BITS = 24,
  parameter int FRAC_BITS  = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                ack,
  input  logic signed [COUNT_BITS-1:0]        count,
  input  logic [dqc_pkg::CPR_W-1:0]           cpr,
  input  logic [dqc_pkg::MS_W-1:0]            ms,
  output logic [dqc_pkg::RPM_W-1:0]           rpm,
  output dqc_pkg::spd_stat_t                  stat
);
  import dqc_pkg::*;

  localparam int PROD_W = COUNT_BITS + 16;
  localparam int NUM_W  = PROD_W + FRAC_BITS;
  localparam int CW     = $clog2(NUM_W + 1);
  localparam int QX     = (NUM_W > RPM_W + 1) ? NUM_W : RPM_W + 1;

  typedef enum logic [2:0] {IDLE, MUL, DIV, FIN, HOLD} state_t;

  state_t              state;
  logic                neg;
  logic [COUNT_BITS-1:0] mag;
  logic [CPR_W-1:0]    cpr_r;
  logic [MS_W-1:0]     ms_r;
  logic [NUM_W-1:0]    num;
  logic [DEN_W-1:0]    den;
  logic [DEN_W-1:0]    rem;
  logic [CW-1:0]       cnt;

  logic [PROD_W-1:0]   prod;
  logic [DEN_W:0]      rem_sh;
  logic [DEN_W:0]      diff;
  logic                ge;
  logic [QX-1:0]       qx;
  logic [QX-1:0]       lim;
  logic [RPM_W-1:0]    mcl;

  always_comb begin
    prod   = PROD_W'(mag) * PROD_W'(MS_PER_MIN);
    rem_sh = {rem, num[NUM_W-1]};
    diff   = rem_sh - {1'b0, den};
    ge     = rem_sh >= {1'b0, den};
    qx     = QX'(num);
    lim    = neg ? QX'(33'h0_8000_0000) : QX'(33'h0_7FFF_FFFF);
    mcl    = (qx > lim) ? lim[RPM_W-1:0] : qx[RPM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (start) begin
            neg   <= count[COUNT_BITS-1];
            mag   <= count[COUNT_BITS-1] ? COUNT_BITS'(-count) : COUNT_BITS'(count);
            cpr_r <= (cpr == '0) ? CPR_W'(1) : cpr;
            ms_r  <= ms;
            state <= MUL;
          end
        end
        MUL: begin
          num   <= NUM_W'(prod) << FRAC_BITS;
          den   <= DEN_W'(cpr_r) * DEN_W'(ms_r);
          rem   <= '0;
          cnt   <= CW'(NUM_W);
          state <= DIV;
        end
        DIV: begin
          rem <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
          num <= {num[NUM_W-2:0], ge};
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            state <= FIN;
          end
        end
        FIN: begin
          rpm   <= neg ? (RPM_W'(0) - mcl) : mcl;
          state <= HOLD;
        end
        HOLD: begin
          if (ack) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign stat.busy  = (state != IDLE);
  assign stat.ready = (state == HOLD);

endmodule

// ===== src/dqc_check.sv =====
module dqc_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_window_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[79:64] != 16'd0))
    else $error("window length of zero");

  a_result_after_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result without a preceding speed calculation");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind dual_quadrature_counter_rpm dqc_check u_dqc_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== tb/tb_dual_quadrature_counter_rpm.sv =====
`timescale 1ns / 1ps

module tb_dual_quadrature_counter_rpm;
  import dqc_pkg::*;

  localparam int COUNT_BITS = 24;
  localparam int FRAC_BITS = 8;
  localparam int TALLY_MAX = (1 << (COUNT_BITS - 1)) - 1;
  localparam int TALLY_MIN = -TALLY_MAX - 1;
  localparam int SETTLE_CYCLES = COUNT_BITS + FRAC_BITS + 19 + 10;
  localparam int HOLD_CYCLES = 400;
  localparam longint CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    logic ms_tick;
    logic right_b;
    logic right_a;
    logic left_b;
    logic left_a;
  } enc_sample_t;

  typedef struct packed {
    logic [15:0] window_ms;
    logic signed [31:0] right_rpm;
    logic signed [31:0] left_rpm;
  } speed_res_t;

  typedef struct packed {
    int spin;
    enc_sample_t smp;
    bit typed;
    logic signed [31:0] left_rpm;
    logic signed [31:0] right_rpm;
    logic [15:0] window_ms;
  } dir_row_t;

  typedef struct packed {
    logic [15:0] cpr;
    logic [15:0] ivl;
    int items;
    int tick_pct;
    int gap_max;
    bit hold;
    bit pause;
  } phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic cfg_wen = 1'b0;
  logic [0:0] cfg_index = REG_COUNTS_PER_REV;
  logic [15:0] cfg_wdata = '0;

  dual_quadrature_counter_rpm dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_wen(cfg_wen),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // mirror of the block state
  logic [15:0] cpr_reg = 16'd1;
  logic [15:0] ivl_reg = 16'd100;
  logic [3:0] pins_prev = '0;
  int left_count = 0;
  int right_count = 0;
  int ms_elapsed = 0;

  speed_res_t speed_due[$];
  int mismatches = 0;
  int burst_left = 0;
  int gap_max = 4;
  bit hold_req = 0;

  // left_a left_b right_a right_b ms_tick, msb first: tick rb ra lb la
  dir_row_t dir_rows [10] = '{
    '{0, 5'b11001, 1'b1, -32'sd15360000, 32'sd15360000, 16'd1},
    '{0, 5'b01111, 1'b0, 32'sd0, 32'sd0, 16'd0},
    '{0, 5'b10000, 1'b1, -32'sd15360000, 32'sd15360000, 16'd1},
    '{200, 5'b10000, 1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'd1},
    '{0, 5'b10000, 1'b1, 32'sd0, 32'sd0, 16'd1},
    '{0, 5'b00011, 1'b0, 32'sd0, 32'sd0, 16'd0},
    '{0, 5'b00110, 1'b0, 32'sd0, 32'sd0, 16'd0},
    '{0, 5'b11100, 1'b0, 32'sd0, 32'sd0, 16'd0},
    '{0, 5'b01010, 1'b0, 32'sd0, 32'sd0, 16'd0},
    '{0, 5'b10101, 1'b0, 32'sd0, 32'sd0, 16'd0}
  };

  phase_t phases [8] = '{
    '{16'd1, 16'd1, 150, 30, 4, 1'b0, 1'b0},
    '{16'd0, 16'd0, 150, 40, 6, 1'b0, 1'b0},
    '{16'd65535, 16'd3, 200, 50, 3, 1'b0, 1'b0},
    '{16'd3, 16'd100, 200, 100, 2, 1'b0, 1'b0},
    '{16'd1, 16'd2, 200, 10, 8, 1'b0, 1'b0},
    '{16'd7, 16'd65535, 64, 100, 1, 1'b0, 1'b0},
    '{16'd360, 16'd5, 300, 60, 0, 1'b1, 1'b0},
    '{16'd1, 16'd1, 300, 100, 5, 1'b0, 1'b1}
  };

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int tally_step(int t, logic a0, logic b0, logic a1, logic b1);
    int dir;
    dir = 0;
    if (a0 != a1 && b0 == b1) dir = (a1 == b1) ? 1 : -1;
    else if (b0 != b1 && a0 == a1) dir = (a1 != b1) ? 1 : -1;
    if (dir > 0 && t < TALLY_MAX) t++;
    else if (dir < 0 && t > TALLY_MIN) t--;
    return t;
  endfunction

  function automatic logic [31:0] speed_q(int t, longint unsigned den);
    bit neg;
    longint unsigned mag, num, q, r, lim, m;
    neg = t < 0;
    mag = neg ? longint'(-t) : longint'(t);
    num = mag * MS_PER_MIN;
    q = num / den;
    r = num % den;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (q >= 64'h1_0000_0000) begin
      m = lim;
    end else begin
      m = (q << FRAC_BITS) + ((r << FRAC_BITS) / den);
      if (m > lim) m = lim;
    end
    if (neg) m = 64'd0 - m;
    return m[31:0];
  endfunction

  function automatic bit encoder_advance(enc_sample_t s, output speed_res_t res);
    longint unsigned den;
    int need;
    left_count = tally_step(left_count, pins_prev[0], pins_prev[1], s.left_a, s.left_b);
    right_count = tally_step(right_count, pins_prev[2], pins_prev[3], s.right_a, s.right_b);
    pins_prev = {s.right_b, s.right_a, s.left_b, s.left_a};
    if (s.ms_tick && ms_elapsed < 65535) ms_elapsed++;
    need = (ivl_reg == 0) ? 1 : int'(ivl_reg);
    res = '0;
    if (ms_elapsed < need) return 1'b0;
    den = longint'((cpr_reg == 0) ? 16'd1 : cpr_reg) * longint'(ms_elapsed);
    res.left_rpm = speed_q(left_count, den);
    res.right_rpm = speed_q(right_count, den);
    res.window_ms = ms_elapsed[15:0];
    left_count = 0;
    right_count = 0;
    ms_elapsed = 0;
    return 1'b1;
  endfunction

  // ab holds {b, a}
  function automatic logic [1:0] quad_step(logic [1:0] ab, bit up);
    if (up == (ab[0] == ab[1])) return ab ^ 2'b10;
    return ab ^ 2'b01;
  endfunction

  function automatic logic [1:0] wheel_next(logic [1:0] ab, int mode);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 2'($urandom_range(0, 3));
    if (r < 20) return ab;
    return quad_step(ab, mode == 0 || (mode == 2 && $urandom_range(0, 1) == 1));
  endfunction

  function automatic void check_result(speed_res_t got);
    speed_res_t want;
    if (speed_due.size() == 0) begin
      $display("%0t: result with nothing outstanding, got %h", $time, got);
      mismatches++;
      return;
    end
    want = speed_due.pop_front();
    if (got.left_rpm !== want.left_rpm) begin
      $display("%0t: left_rpm expected %0d got %0d", $time, want.left_rpm, got.left_rpm);
      mismatches++;
    end
    if (got.right_rpm !== want.right_rpm) begin
      $display("%0t: right_rpm expected %0d got %0d", $time, want.right_rpm, got.right_rpm);
      mismatches++;
    end
    if (got.window_ms !== want.window_ms) begin
      $display("%0t: window_ms expected %0d got %0d", $time, want.window_ms, got.window_ms);
      mismatches++;
    end
  endfunction

  task automatic send_sample(enc_sample_t smp, bit typed, speed_res_t typed_res);
    int gap;
    speed_res_t res;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, smp};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (encoder_advance(smp, res)) speed_due.push_back(typed ? typed_res : res);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (speed_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [15:0] val);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == REG_COUNTS_PER_REV) cpr_reg = val;
    else ivl_reg = val;
  endtask

  // receiver: random stall pattern, long hold on request
  initial begin
    int stall_pct;
    int mode_left;
    int hold_left;
    stall_pct = 0;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) check_result(speed_res_t'(m_tdata));
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (mode_left <= 0) begin
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 80;
          endcase
          mode_left = $urandom_range(50, 500);
        end
        mode_left--;
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin
    longint cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("tb_dual_quadrature_counter_rpm: FAIL");
        $finish;
      end
    end
  end

  initial begin
    enc_sample_t smp;
    speed_res_t typed_res;
    phase_t ph;
    int lmode, rmode;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    write_reg(REG_INTERVAL_MS, 16'd1);
    cfg_wen <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      for (int k = 0; k < dir_rows[i].spin; k++) begin
        smp = {1'b0, quad_step(pins_prev[3:2], 1'b0), quad_step(pins_prev[1:0], 1'b1)};
        send_sample(smp, 1'b0, '0);
      end
      typed_res = '{dir_rows[i].window_ms, dir_rows[i].right_rpm, dir_rows[i].left_rpm};
      send_sample(dir_rows[i].smp, dir_rows[i].typed, typed_res);
    end
    drain();

    foreach (phases[p]) begin
      ph = phases[p];
      write_reg(REG_COUNTS_PER_REV, ph.cpr);
      write_reg(REG_INTERVAL_MS, ph.ivl);
      cfg_wen <= 1'b0;
      gap_max = ph.gap_max;
      if (ph.hold) hold_req = 1;
      lmode = 2;
      rmode = 2;
      for (int n = 0; n < ph.items; n++) begin
        if (n % 32 == 0) begin
          lmode = $urandom_range(0, 2);
          rmode = $urandom_range(0, 2);
        end
        if (ph.pause && n == ph.items / 2) begin
          // sender waits until every request is answered
          s_tvalid <= 1'b0;
          burst_left = 0;
          while (speed_due.size() != 0) @(posedge clk);
          @(posedge clk);
        end
        smp.ms_tick = ($urandom_range(0, 99) < ph.tick_pct);
        {smp.left_b, smp.left_a} = wheel_next(pins_prev[1:0], lmode);
        {smp.right_b, smp.right_a} = wheel_next(pins_prev[3:2], rmode);
        send_sample(smp, 1'b0, '0);
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("tb_dual_quadrature_counter_rpm: PASS");
    end else begin
      $display("tb_dual_quadrature_counter_rpm: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/dqc_pkg.sv
src/dqc_tally.sv
src/dqc_speed.sv
src/dual_quadrature_counter_rpm.sv
src/dqc_check.sv
tb/tb_dual_quadrature_counter_rpm.sv
